// File: rtl/core/bal_pkg.sv
package bal_pkg;

    localparam int TYPE_W = 2;
    localparam int SIZE_W = 16;
    localparam int ADDR_W = 16;
    localparam int ST_W   = 2;
    localparam int ORD_W  = 5;
    localparam int OORD_W = 4;
    localparam int CLEN_W = 14;
    localparam int CFG_W  = 3;

    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REALLOC = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_MEM   = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_PTR  = 2'd3;

    localparam logic [CFG_W-1:0] MAX_TOP_RESET = 3'd4;

    typedef struct packed {
        logic              allocated;
        logic [ORD_W-1:0]  order;
        logic              padded;
        logic [SIZE_W-1:0] rsize;
    } bal_hdr_t;

    function automatic bal_hdr_t hdr_free(input logic [ORD_W-1:0] k);
        bal_hdr_t h;
        h.allocated = 1'b0;
        h.order     = k;
        h.padded    = 1'b0;
        h.rsize     = '0;
        return h;
    endfunction

endpackage

// File: rtl/core/bal_if.sv
interface bal_req_if import bal_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
    logic              address_present;

    modport source (output valid, req_type, request_size, block_address, address_present,
                    input ready);
    modport sink   (input valid, req_type, request_size, block_address, address_present,
                    output ready);
endinterface

interface bal_rsp_if import bal_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] result_address;
    logic              result_present;
    logic              copy_needed;
    logic [CLEN_W-1:0] copy_length;
    logic [OORD_W-1:0] granted_order;

    modport source (output valid, status, result_address, result_present, copy_needed,
                    copy_length, granted_order, input ready);
    modport sink   (input valid, status, result_address, result_present, copy_needed,
                    copy_length, granted_order, output ready);
endinterface

interface bal_cfg_if import bal_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/buddy_allocator_unit.sv
// Buddy allocator: one request item at a time, one result item per request.
// Allocate splits down one order at a time (growing the heap first if needed), free
// merges with the buddy one order at a time; both are serial read-modify-write
// sequences on the header and link RAMs.
// A new item is taken while the previous result still waits in the output register.
// Reset empties all free lists and the heap; header and link RAMs are not cleared.
module buddy_allocator_unit import bal_pkg::*;
#(
    parameter int MIN_ORDER       = 5,
    parameter int MAX_ORDER       = 15,
    parameter int HEADER_BYTES    = 8,
    parameter int TOP_BLOCK_LIMIT = 4
)
(
    input logic       clk,
    input logic       rst_n,
    bal_req_if.sink   req,
    bal_rsp_if.source rsp,
    bal_cfg_if.sink   cfg
);

    // Heap geometry in granules of 2^MIN_ORDER bytes.
    localparam int TOP_SHIFT = MAX_ORDER - 1 - MIN_ORDER;
    localparam int GRANULES  = TOP_BLOCK_LIMIT << TOP_SHIFT;
    localparam int GW        = (GRANULES > 1) ? $clog2(GRANULES) : 1;
    // Links carry one extra code, one past the last granule, as the list end.
    localparam int LW        = $clog2(GRANULES + 1);
    localparam int NUM_LISTS = MAX_ORDER - MIN_ORDER;
    localparam int LI_W      = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int UW        = $clog2(TOP_BLOCK_LIMIT + 1);
    localparam logic [LW-1:0] NIL = LW'(GRANULES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_CHKW,
        S_ALLOC,
        S_APULL,
        S_SPLIT,
        S_PUSH2,
        S_FREE,
        S_FLOOP,
        S_FBCHK,
        S_FPULLB,
        S_FRDG,
        S_FPULLG,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        J_ALLOC,
        J_FREE,
        J_REALLOC,
        J_MOVE,
        J_SHRINK
    } job_t;

    // Working context of the item in flight.
    typedef struct packed {
        job_t              job;
        logic [SIZE_W-1:0] rsize;
        logic [ADDR_W-1:0] addr;
        logic              present;
        logic [ORD_W-1:0]  o;
        logic [GW-1:0]     g;
        logic [ORD_W-1:0]  k;
        logic [GW-1:0]     old_g;
        logic [ORD_W-1:0]  old_k;
        logic [SIZE_W-1:0] old_rsize;
        logic [GW-1:0]     pu_g;
        logic [LW-1:0]     pu_n;
        logic              pu_split;
        logic [ST_W-1:0]   st;
        logic              got;
        logic [GW-1:0]     res_g;
        logic [ORD_W-1:0]  ord;
        logic              copy;
        logic [SIZE_W-1:0] clen;
    } ctx_t;

    state_t          state_reg, state_next;
    ctx_t            ctx_reg, ctx_next;
    logic [LW-1:0]   head_reg [NUM_LISTS];
    logic [LW-1:0]   head_next [NUM_LISTS];
    logic [UW-1:0]   used_reg, used_next;
    logic [CFG_W-1:0] max_top_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   out_st_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_present_reg;
    logic              out_copy_reg;
    logic [CLEN_W-1:0] out_clen_reg;
    logic [OORD_W-1:0] out_ord_reg;
    logic              out_load;

    // Header RAM and the two link RAMs: one write and one registered read each.
    bal_hdr_t      hdr_mem [GRANULES];
    logic [LW-1:0] nx_mem [GRANULES];
    logic [LW-1:0] pv_mem [GRANULES];
    bal_hdr_t      hdr_rdata;
    logic [LW-1:0] nx_rdata, pv_rdata;

    logic          hdr_we, nx_we, pv_we;
    logic [GW-1:0] hdr_wa, hdr_ra, nx_wa, pv_wa, lk_ra;
    bal_hdr_t      hdr_wd;
    logic [LW-1:0] nx_wd, pv_wd;

    logic            do_push, do_pull;
    logic [GW-1:0]   push_g;
    logic [LI_W-1:0] push_idx;

    function automatic logic [ORD_W-1:0] fit_order(input logic [SIZE_W-1:0] rs);
        logic [31:0]      need;
        logic [ORD_W-1:0] r;
        need = 32'(rs) + 32'(HEADER_BYTES);
        r    = ORD_W'(MAX_ORDER);
        for (int o = MAX_ORDER - 1; o >= MIN_ORDER; o--)
        begin
            if ((32'(1) << o) >= need)
            begin
                r = ORD_W'(o);
            end
        end
        return r;
    endfunction

    function automatic logic pad_of(input logic [SIZE_W-1:0] rs, input logic [ORD_W-1:0] o);
        return (32'(1) << o) != (32'(rs) + 32'(HEADER_BYTES));
    endfunction

    // ---------------------------------------------------------------------
    // Helpers derived from the context.
    // ---------------------------------------------------------------------
    logic [LI_W-1:0]   kidx, kd_idx, fi;
    logic [ORD_W-1:0]  kd;
    logic [GW-1:0]     split_up, buddy, top_g, ptr_g;
    logic [ADDR_W-1:0] ptr_h;
    logic              ptr_pre_ok, can_grow, fnd, hdr_ok;
    int                lim;

    always_comb
    begin
        kidx     = LI_W'(int'(ctx_reg.k) - MIN_ORDER);
        kd       = ctx_reg.k - ORD_W'(1);
        kd_idx   = LI_W'(int'(kd) - MIN_ORDER);
        split_up = GW'(32'(ctx_reg.g) + (32'(1) << (int'(kd) - MIN_ORDER)));
        buddy    = ctx_reg.g ^ GW'(32'(1) << (int'(ctx_reg.k) - MIN_ORDER));
        top_g    = GW'(32'(used_reg) << TOP_SHIFT);

        // Pointer checks that need no header: non-null, aligned, inside the heap.
        ptr_h      = ctx_reg.addr - ADDR_W'(HEADER_BYTES);
        ptr_g      = GW'(32'(ptr_h) >> MIN_ORDER);
        ptr_pre_ok = ctx_reg.present
                  && (32'(ctx_reg.addr) >= 32'(HEADER_BYTES))
                  && (ptr_h[MIN_ORDER-1:0] == '0)
                  && ((32'(ptr_h) >> MIN_ORDER) < (32'(used_reg) << TOP_SHIFT));

        // Header checks on the word just read.
        hdr_ok = hdr_rdata.allocated
              && (32'(hdr_rdata.order) >= 32'(MIN_ORDER))
              && (32'(hdr_rdata.order) < 32'(MAX_ORDER))
              && (fit_order(hdr_rdata.rsize) == hdr_rdata.order)
              && (hdr_rdata.padded == pad_of(hdr_rdata.rsize, hdr_rdata.order));

        lim      = (int'(max_top_reg) < TOP_BLOCK_LIMIT) ? int'(max_top_reg) : TOP_BLOCK_LIMIT;
        can_grow = int'(used_reg) < lim;

        // Lowest non-empty list that can hold the target order.
        fnd = 1'b0;
        fi  = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--)
        begin
            if ((i >= int'(ctx_reg.o) - MIN_ORDER) && (head_reg[i] != NIL))
            begin
                fnd = 1'b1;
                fi  = LI_W'(i);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state, context and RAM requests.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        head_next  = head_reg;
        used_next  = used_reg;
        hdr_we     = 1'b0;
        hdr_wa     = ctx_reg.g;
        hdr_wd     = hdr_free(ctx_reg.k);
        hdr_ra     = ctx_reg.g;
        nx_we      = 1'b0;
        nx_wa      = ctx_reg.g;
        nx_wd      = NIL;
        pv_we      = 1'b0;
        pv_wa      = ctx_reg.g;
        pv_wd      = NIL;
        lk_ra      = ctx_reg.g;
        do_push    = 1'b0;
        do_pull    = 1'b0;
        push_g     = ctx_reg.g;
        push_idx   = kidx;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ctx_next.rsize   = req.request_size;
                    ctx_next.addr    = req.block_address;
                    ctx_next.present = req.address_present;
                    ctx_next.o       = fit_order(req.request_size);
                    ctx_next.st      = ST_OK;
                    ctx_next.got     = 1'b0;
                    ctx_next.res_g   = '0;
                    ctx_next.ord     = '0;
                    ctx_next.copy    = 1'b0;
                    ctx_next.clen    = '0;
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            ctx_next.job = J_ALLOC;
                            state_next   = S_ALLOC;
                        end
                        REQ_FREE:
                        begin
                            ctx_next.job = J_FREE;
                            state_next   = S_CHK;
                        end
                        REQ_REALLOC:
                        begin
                            // null pointer: plain allocate
                            ctx_next.job = req.address_present ? J_REALLOC : J_ALLOC;
                            state_next   = req.address_present ? S_CHK : S_ALLOC;
                        end
                        default:
                        begin
                            // unused request code: null ok result, free lists and heap untouched
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_CHK:
            begin
                if (!ptr_pre_ok)
                begin
                    ctx_next.st = ST_BAD_PTR;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctx_next.g = ptr_g;
                    hdr_ra     = ptr_g;
                    state_next = S_CHKW;
                end
            end

            S_CHKW:
            begin
                if (!hdr_ok)
                begin
                    ctx_next.st = ST_BAD_PTR;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctx_next.old_g     = ctx_reg.g;
                    ctx_next.old_k     = hdr_rdata.order;
                    ctx_next.old_rsize = hdr_rdata.rsize;
                    ctx_next.k         = hdr_rdata.order;
                    if (ctx_reg.job == J_FREE || ctx_reg.rsize == '0)
                    begin
                        state_next = S_FREE;
                    end
                    else if (32'(ctx_reg.o) >= 32'(MAX_ORDER))
                    begin
                        // bad size keeps the block
                        ctx_next.st = ST_BAD_SIZE;
                        state_next  = S_DONE;
                    end
                    else if (ctx_reg.o > hdr_rdata.order)
                    begin
                        ctx_next.job = J_MOVE;
                        state_next   = S_ALLOC;
                    end
                    else
                    begin
                        ctx_next.job = J_SHRINK;
                        state_next   = S_SPLIT;
                    end
                end
            end

            S_ALLOC:
            begin
                if (ctx_reg.job == J_ALLOC
                    && (ctx_reg.rsize == '0 || 32'(ctx_reg.o) >= 32'(MAX_ORDER)))
                begin
                    ctx_next.st = ST_BAD_SIZE;
                    state_next  = S_DONE;
                end
                else if (fnd)
                begin
                    // take the list head, fetch its links for the unlink
                    ctx_next.g = head_reg[fi][GW-1:0];
                    ctx_next.k = ORD_W'(int'(fi) + MIN_ORDER);
                    lk_ra      = head_reg[fi][GW-1:0];
                    state_next = S_APULL;
                end
                else if (!can_grow)
                begin
                    // a failed move lands here too and keeps the old block
                    ctx_next.st = ST_NO_MEM;
                    state_next  = S_DONE;
                end
                else
                begin
                    // grow by one top block; its list is empty so the push needs no back-link fix-up
                    hdr_we    = 1'b1;
                    hdr_wa    = top_g;
                    hdr_wd    = hdr_free(ORD_W'(MAX_ORDER - 1));
                    do_push   = 1'b1;
                    push_g    = top_g;
                    push_idx  = LI_W'(NUM_LISTS - 1);
                    used_next = UW'(32'(used_reg) + 32'd1);
                end
            end

            S_APULL:
            begin
                do_pull    = 1'b1;
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                if (ctx_reg.k > ctx_reg.o)
                begin
                    // free the upper half one order down
                    hdr_we            = 1'b1;
                    hdr_wa            = split_up;
                    hdr_wd            = hdr_free(kd);
                    do_push           = 1'b1;
                    push_g            = split_up;
                    push_idx          = kd_idx;
                    ctx_next.pu_split = 1'b1;
                    ctx_next.k        = kd;
                    state_next        = S_PUSH2;
                end
                else
                begin
                    hdr_we           = 1'b1;
                    hdr_wa           = ctx_reg.g;
                    hdr_wd.allocated = 1'b1;
                    hdr_wd.order     = ctx_reg.o;
                    hdr_wd.padded    = pad_of(ctx_reg.rsize, ctx_reg.o);
                    hdr_wd.rsize     = ctx_reg.rsize;
                    ctx_next.got     = 1'b1;
                    ctx_next.res_g   = ctx_reg.g;
                    ctx_next.ord     = ctx_reg.o;
                    if (ctx_reg.job == J_MOVE)
                    begin
                        // moved: hand back the old block
                        ctx_next.copy = 1'b1;
                        ctx_next.clen = ctx_reg.old_rsize;
                        ctx_next.g    = ctx_reg.old_g;
                        ctx_next.k    = ctx_reg.old_k;
                        state_next    = S_FREE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_PUSH2:
            begin
                if (ctx_reg.pu_n != NIL)
                begin
                    pv_we = 1'b1;
                    pv_wa = ctx_reg.pu_n[GW-1:0];
                    pv_wd = LW'(ctx_reg.pu_g);
                end
                state_next = ctx_reg.pu_split ? S_SPLIT : S_FLOOP;
            end

            S_FREE:
            begin
                hdr_we            = 1'b1;
                do_push           = 1'b1;
                ctx_next.pu_split = 1'b0;
                state_next        = S_PUSH2;
            end

            S_FLOOP:
            begin
                if (32'(ctx_reg.k) >= 32'(MAX_ORDER - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    hdr_ra     = buddy;
                    state_next = S_FBCHK;
                end
            end

            S_FBCHK:
            begin
                if (hdr_rdata.allocated || hdr_rdata.order != ctx_reg.k)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lk_ra      = buddy;
                    state_next = S_FPULLB;
                end
            end

            S_FPULLB:
            begin
                do_pull    = 1'b1;
                state_next = S_FRDG;
            end

            S_FRDG:
            begin
                // read after the buddy unlink has landed
                lk_ra      = ctx_reg.g;
                state_next = S_FPULLG;
            end

            S_FPULLG:
            begin
                do_pull    = 1'b1;
                ctx_next.g = (buddy < ctx_reg.g) ? buddy : ctx_reg.g;
                ctx_next.k = ctx_reg.k + ORD_W'(1);
                state_next = S_FREE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // push onto a list head: new links for the block, head moves
        if (do_push)
        begin
            nx_we              = 1'b1;
            nx_wa              = push_g;
            nx_wd              = head_reg[push_idx];
            pv_we              = 1'b1;
            pv_wa              = push_g;
            pv_wd              = NIL;
            head_next[push_idx] = LW'(push_g);
            ctx_next.pu_g      = push_g;
            ctx_next.pu_n      = head_reg[push_idx];
        end

        // unlink using the links read in the previous cycle
        if (do_pull)
        begin
            if (pv_rdata != NIL)
            begin
                nx_we = 1'b1;
                nx_wa = pv_rdata[GW-1:0];
                nx_wd = nx_rdata;
            end
            else
            begin
                head_next[kidx] = nx_rdata;
            end
            if (nx_rdata != NIL)
            begin
                pv_we = 1'b1;
                pv_wa = nx_rdata[GW-1:0];
                pv_wd = pv_rdata;
            end
        end
    end

    // ---------------------------------------------------------------------
    // RAMs
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_wa] <= hdr_wd;
        end
        hdr_rdata <= hdr_mem[hdr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            nx_mem[nx_wa] <= nx_wd;
        end
        nx_rdata <= nx_mem[lk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            pv_mem[pv_wa] <= pv_wd;
        end
        pv_rdata <= pv_mem[lk_ra];
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            max_top_reg   <= MAX_TOP_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            if (cfg.valid)
            begin
                max_top_reg <= cfg.data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Context and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
        if (out_load)
        begin
            out_st_reg      <= ctx_reg.st;
            out_present_reg <= ctx_reg.got;
            out_copy_reg    <= ctx_reg.copy;
            out_clen_reg    <= ctx_reg.clen[CLEN_W-1:0];
            out_ord_reg     <= ctx_reg.ord[OORD_W-1:0];
            out_addr_reg    <= ctx_reg.got
                             ? ADDR_W'((32'(ctx_reg.res_g) << MIN_ORDER) + 32'(HEADER_BYTES))
                             : '0;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_st_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.result_present = out_present_reg;
    assign rsp.copy_needed    = out_copy_reg;
    assign rsp.copy_length    = out_clen_reg;
    assign rsp.granted_order  = out_ord_reg;

endmodule
